// File: design/gregorian_date_difference_top_defines.svh
// Assertion macros shared by the date difference design files.
// Depends on clk_i and rst_ni being present in the module that uses them.
`ifndef GREGORIAN_DATE_DIFFERENCE_TOP_DEFINES_SVH
`define GREGORIAN_DATE_DIFFERENCE_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk_i, off during reset.
`define GDD_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("%m: assertion failed");
// Next-cycle implication, sampled on clk_i, off during reset.
`define GDD_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("%m: assertion failed");
`else
`define GDD_ASSERT_IMP(lbl, ante, cons)
`define GDD_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

// File: design/gdd_pkg.sv
// Shared types, widths and constants of the date difference pipeline.
// No dependencies.
`timescale 1ns / 1ps

package gdd_pkg;

  localparam int YEAR_W  = 14;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int RES_W   = 23;

  // Largest year taken as given; larger years clamp to it.
  localparam int MAX_YEAR = 9999;

  // Days from year 0 up to any 14-bit date fit in 23 unsigned bits.
  localparam int COUNT_W = 23;
  // Signed width of a difference of two counts plus one.
  localparam int DIFF_W  = COUNT_W + 2;

  localparam int RES_MAX = (1 << (RES_W - 1)) - 1;
  localparam int RES_MIN = -(1 << (RES_W - 1));

  // x / 25 == (x * DIV25_MUL) >> DIV25_SHIFT for every x below 43690.
  localparam int DIV_IN_W    = 13;
  localparam int DIV_PROD_W  = 2 * DIV_IN_W;
  localparam int DIV25_SHIFT = 17;
  localparam logic [DIV_IN_W-1:0] DIV25_MUL = DIV_IN_W'(5243);
  localparam int QUOT_W      = DIV_PROD_W - DIV25_SHIFT;

  localparam int MOFF_W = 9;    // cumulative month days, up to 365
  localparam int DOY_W  = 10;   // day of year, up to 396

  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
  } date_t;

  typedef struct packed {
    logic valid;
    logic ordered;
  } cmp_t;

  // Days in the months ahead of the given one in a common year.
  // Month zero counts nothing, months past December count the full year.
  function automatic logic [MOFF_W-1:0] month_offset(input logic [MONTH_W-1:0] m);
    logic [MOFF_W-1:0] r;
    case (m)
      4'd0, 4'd1: r = MOFF_W'(0);
      4'd2:       r = MOFF_W'(31);
      4'd3:       r = MOFF_W'(59);
      4'd4:       r = MOFF_W'(90);
      4'd5:       r = MOFF_W'(120);
      4'd6:       r = MOFF_W'(151);
      4'd7:       r = MOFF_W'(181);
      4'd8:       r = MOFF_W'(212);
      4'd9:       r = MOFF_W'(243);
      4'd10:      r = MOFF_W'(273);
      4'd11:      r = MOFF_W'(304);
      4'd12:      r = MOFF_W'(334);
      default:    r = MOFF_W'(365);
    endcase
    return r;
  endfunction

endpackage

// File: design/gdd_day_count.sv
// Two-stage day number of one date: days from year 0 to the given day.
// Depends on gdd_pkg.
`timescale 1ns / 1ps

module gdd_day_count (
  input  logic                         clk_i,
  input  gdd_pkg::date_t               date_i,
  output logic [gdd_pkg::COUNT_W-1:0]  count_o
);

  localparam int YW = gdd_pkg::YEAR_W;
  localparam int IW = gdd_pkg::DIV_IN_W;
  localparam int PW = gdd_pkg::DIV_PROD_W;
  localparam int QW = gdd_pkg::QUOT_W;
  localparam int CW = gdd_pkg::COUNT_W;

  // ---- stage A: constant products ----
  logic [YW:0]    yp99, yp399;
  logic [IW-1:0]  x100, x400, x4;

  logic [CW-1:0]            y365_q, y365_d;
  logic [IW-1:0]            q4_q, q4_d;
  logic [PW-1:0]            p100_q, p100_d, p400_q, p400_d, pm_q, pm_d;
  logic [IW-1:0]            x4_q;
  logic [3:0]               ylow_q;
  logic [gdd_pkg::DOY_W-1:0] doy_q, doy_d;
  logic                     late_q, late_d;

  always_comb begin
    yp99   = (YW+1)'(date_i.year) + (YW+1)'(99);
    yp399  = (YW+1)'(date_i.year) + (YW+1)'(399);
    x100   = IW'(yp99 >> 2);
    x400   = IW'(yp399 >> 4);
    x4     = IW'(date_i.year >> 2);
    y365_d = CW'(date_i.year) * CW'(365);
    q4_d   = IW'(((YW+1)'(date_i.year) + (YW+1)'(3)) >> 2);
    p100_d = PW'(x100) * PW'(gdd_pkg::DIV25_MUL);
    p400_d = PW'(x400) * PW'(gdd_pkg::DIV25_MUL);
    pm_d   = PW'(x4) * PW'(gdd_pkg::DIV25_MUL);
    doy_d  = gdd_pkg::DOY_W'(gdd_pkg::month_offset(date_i.month))
           + gdd_pkg::DOY_W'(date_i.day);
    late_d = (date_i.month >= gdd_pkg::MONTH_W'(3));
  end

  always_ff @(posedge clk_i) begin
    y365_q <= y365_d;
    q4_q   <= q4_d;
    p100_q <= p100_d;
    p400_q <= p400_d;
    pm_q   <= pm_d;
    x4_q   <= x4;
    ylow_q <= date_i.year[3:0];
    doy_q  <= doy_d;
    late_q <= late_d;
  end

  // ---- stage B: quotients, leap year, sum ----
  logic [QW-1:0] q100, q400, qm;
  logic [IW-1:0] rem25;
  logic          leap;
  logic [CW-1:0] count_d, count_q;

  always_comb begin
    q100  = p100_q[PW-1:gdd_pkg::DIV25_SHIFT];
    q400  = p400_q[PW-1:gdd_pkg::DIV25_SHIFT];
    qm    = pm_q[PW-1:gdd_pkg::DIV25_SHIFT];
    rem25 = x4_q - IW'(IW'(qm) * IW'(25));
    // A multiple of 100 is a multiple of 400 exactly when it is one of 16.
    leap  = (ylow_q[1:0] == 2'b00) && ((ylow_q[3:2] == 2'b00) || (rem25 != '0));
    count_d = y365_q + CW'(q4_q) - CW'(q100) + CW'(q400)
            + CW'(doy_q) + CW'(leap && late_q);
  end

  always_ff @(posedge clk_i) begin
    count_q <= count_d;
  end

  assign count_o = count_q;

endmodule

// File: design/gdd_result.sv
// Output stage: subtracts the day numbers, saturates, gives minus one for a pair out of order, and drives the strobe.
// Depends on gdd_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "gregorian_date_difference_top_defines.svh"

module gdd_result (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  gdd_pkg::cmp_t                      ctl_i,
  input  logic                               include_end_day_i,
  input  logic [gdd_pkg::COUNT_W-1:0]        count1_i,
  input  logic [gdd_pkg::COUNT_W-1:0]        count2_i,
  output logic                               done_o,
  output logic signed [gdd_pkg::RES_W-1:0]   days_between_o
);

  localparam int DW = gdd_pkg::DIFF_W;
  localparam int RW = gdd_pkg::RES_W;

  logic signed [DW-1:0] diff;
  logic signed [RW-1:0] res_d, res_q;
  logic                 done_q;

  always_comb begin
    diff = $signed(DW'(count2_i)) - $signed(DW'(count1_i))
         + $signed(DW'(include_end_day_i));
    if (!ctl_i.ordered) begin
      res_d = '1;
    end else if (diff > DW'(gdd_pkg::RES_MAX)) begin
      res_d = RW'(gdd_pkg::RES_MAX);
    end else if (diff < $signed(DW'(gdd_pkg::RES_MIN))) begin
      res_d = RW'(gdd_pkg::RES_MIN);
    end else begin
      res_d = RW'(diff);
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= ctl_i.valid;
    end
  end

  assign done_o         = done_q;
  assign days_between_o = res_q;

  // A pair out of order always reports minus one.
  `GDD_ASSERT_NXT(a_unordered_minus_one, ctl_i.valid && !ctl_i.ordered,
                  done_o && (days_between_o == -1))

endmodule

// File: design/gregorian_date_difference_top.sv
// Top level of the Gregorian date difference pipeline.
// Depends on gdd_pkg, gdd_day_count, gdd_result and the assertion macro header.
`timescale 1ns / 1ps
`include "gregorian_date_difference_top_defines.svh"

// Channel     Direction  Handshake                 Payload
// command     in         start_i, busy_o           first_*_i, second_*_i
// result      out        done_o (one-cycle strobe) days_between_o
// config      in         cfg_we_i                  cfg_wdata_i (include end day)
//
// One transaction is taken every cycle; busy_o stays low.
// A result strobes on done_o once the transaction taken on start_i has passed
// the clamp stage, product stage, sum stage and output stage.
// The depth is set by the day-number unit: constant products, then sums.
// Reset clears the valid bits and the done strobe and sets include end day.
// The receiver cannot stall, so the pipeline never holds.

module gregorian_date_difference_top #(
  parameter int MAX_YEAR = gdd_pkg::MAX_YEAR
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  output logic                                busy_o,
  input  logic                                cfg_we_i,
  input  logic                                cfg_wdata_i,
  input  logic [gdd_pkg::YEAR_W-1:0]          first_year_i,
  input  logic [gdd_pkg::MONTH_W-1:0]         first_month_i,
  input  logic [gdd_pkg::DAY_W-1:0]           first_day_i,
  input  logic [gdd_pkg::YEAR_W-1:0]          second_year_i,
  input  logic [gdd_pkg::MONTH_W-1:0]         second_month_i,
  input  logic [gdd_pkg::DAY_W-1:0]           second_day_i,
  output logic                                done_o,
  output logic signed [gdd_pkg::RES_W-1:0]    days_between_o
);

  localparam int YW = gdd_pkg::YEAR_W;

  // Never stall: every stage advances each cycle.
  assign busy_o = 1'b0;

  logic accept;
  assign accept = start_i && !busy_o;

  // Include-end-day register; to be written only while idle, which the block itself does not enforce.
  logic incl_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      incl_q <= 1'b1;
    end else if (cfg_we_i) begin
      incl_q <= cfg_wdata_i;
    end
  end

  // ---- stage 1: clamp years and capture both dates ----
  gdd_pkg::date_t date1_d, date2_d, date1_q, date2_q;

  always_comb begin
    date1_d.year  = (32'(first_year_i) > MAX_YEAR) ?
                    YW'(MAX_YEAR) : first_year_i;
    date1_d.month = first_month_i;
    date1_d.day   = first_day_i;
    date2_d.year  = (32'(second_year_i) > MAX_YEAR) ?
                    YW'(MAX_YEAR) : second_year_i;
    date2_d.month = second_month_i;
    date2_d.day   = second_day_i;
  end

  always_ff @(posedge clk_i) begin
    date1_q <= date1_d;
    date2_q <= date2_d;
  end

  // Valid bits travel alongside the data; one per stage.
  logic v1_q, v2_q, v3_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= accept;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  // ---- stage 2/3: order test, delayed to meet the day numbers ----
  // Packed compare orders by year, then month, then day.
  logic before2_q, before3_q;
  always_ff @(posedge clk_i) begin
    before2_q <= (date1_q < date2_q);
    before3_q <= before2_q;
  end

  logic [gdd_pkg::COUNT_W-1:0] count1, count2;

  gdd_day_count u_count1 (
    .clk_i   (clk_i),
    .date_i  (date1_q),
    .count_o (count1)
  );

  gdd_day_count u_count2 (
    .clk_i   (clk_i),
    .date_i  (date2_q),
    .count_o (count2)
  );

  // ---- stage 4: subtract, saturate, strobe ----
  gdd_pkg::cmp_t ctl3;
  assign ctl3.valid   = v3_q;
  assign ctl3.ordered = before3_q;

  gdd_result u_result (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .ctl_i             (ctl3),
    .include_end_day_i (incl_q),
    .count1_i          (count1),
    .count2_i          (count2),
    .done_o            (done_o),
    .days_between_o    (days_between_o)
  );

  // Every transaction taken comes out as a strobe on done_o.
  `GDD_ASSERT_IMP(a_fixed_latency, accept, ##4 done_o)
  // No strobe without a transaction in the last stage.
  `GDD_ASSERT_NXT(a_no_spurious_done, !v3_q, !done_o)
  // A valid last stage must strobe on the next cycle.
  `GDD_ASSERT_NXT(a_done_follows_valid, v3_q, done_o)

endmodule

// File: test/tb_top.sv
// Self-checking testbench for gregorian_date_difference_top: drives date pairs, predicts day spans.
// Depends on gdd_pkg and the design sources; needs no other files.
`timescale 1ns / 1ps

class day_span_board;
  int unsigned include_end;
  logic signed [gdd_pkg::RES_W-1:0] expected_spans[$];
  int unsigned mismatches;

  function new();
    include_end = 1;
    mismatches = 0;
  endfunction

  function bit is_leap(int y);
    return ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
  endfunction

  function int days_in_month(int y, int m);
    case (m)
      2:              return is_leap(y) ? 29 : 28;
      4, 6, 9, 11:    return 30;
      default:        return 31;
    endcase
  endfunction

  function int clamped_year(logic [gdd_pkg::YEAR_W-1:0] y);
    return (y > gdd_pkg::MAX_YEAR) ? gdd_pkg::MAX_YEAR : int'(y);
  endfunction

  // Days since the start of year 0; months past December count the whole year.
  function longint day_number(int y, int m, int d);
    longint total;
    total = longint'(y) * 365 + (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400 + d;
    for (int i = 1; i < m && i <= 12; i++)
      total += days_in_month(y, i);
    return total;
  endfunction

  function logic signed [gdd_pkg::RES_W-1:0] predict_span(gdd_pkg::date_t a,
                                                           gdd_pkg::date_t b);
    int ya;
    int yb;
    bit start_first;
    longint span;
    ya = clamped_year(a.year);
    yb = clamped_year(b.year);
    if (ya != yb) start_first = ya < yb;
    else if (a.month != b.month) start_first = a.month < b.month;
    else start_first = a.day < b.day;
    if (!start_first) return '1;
    span = day_number(yb, b.month, b.day) - day_number(ya, a.month, a.day) + include_end;
    if (span > gdd_pkg::RES_MAX) span = gdd_pkg::RES_MAX;
    if (span < gdd_pkg::RES_MIN) span = gdd_pkg::RES_MIN;
    return span[gdd_pkg::RES_W-1:0];
  endfunction

  function void note_command(gdd_pkg::date_t a, gdd_pkg::date_t b);
    expected_spans.push_back(predict_span(a, b));
  endfunction

  function void check_span(logic signed [gdd_pkg::RES_W-1:0] actual);
    logic signed [gdd_pkg::RES_W-1:0] want;
    if (expected_spans.size() == 0) begin
      $display("%0t: unexpected days_between, expected none, actual %0d", $time, actual);
      mismatches++;
      return;
    end
    want = expected_spans.pop_front();
    if (actual !== want) begin
      $display("%0t: days_between mismatch, expected %0d, actual %0d", $time, want, actual);
      mismatches++;
    end
  endfunction

  function bit pending();
    return expected_spans.size() != 0;
  endfunction
endclass

module tb_top;
  import gdd_pkg::*;

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      start_i = 1'b0;
  logic                      busy_o;
  logic                      cfg_we_i = 1'b0;
  logic                      cfg_wdata_i = 1'b0;
  logic [YEAR_W-1:0]         first_year_i = '0;
  logic [MONTH_W-1:0]        first_month_i = '0;
  logic [DAY_W-1:0]          first_day_i = '0;
  logic [YEAR_W-1:0]         second_year_i = '0;
  logic [MONTH_W-1:0]        second_month_i = '0;
  logic [DAY_W-1:0]          second_day_i = '0;
  logic                      done_o;
  logic signed [RES_W-1:0]   days_between_o;

  day_span_board board = new();

  // Toggled per chunk of random traffic: when clear, send back to back.
  bit sender_idles = 1'b1;

  gregorian_date_difference_top uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .first_year_i   (first_year_i),
    .first_month_i  (first_month_i),
    .first_day_i    (first_day_i),
    .second_year_i  (second_year_i),
    .second_month_i (second_month_i),
    .second_day_i   (second_day_i),
    .done_o         (done_o),
    .days_between_o (days_between_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Sample on the falling edge: everything driven or registered at the last
  // rising edge has settled, and it is what the next rising edge will take.
  // Check results before noting the new command; they belong to older ones.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (done_o) board.check_span(days_between_o);
      if (start_i && !busy_o)
        board.note_command('{first_year_i, first_month_i, first_day_i},
                           '{second_year_i, second_month_i, second_day_i});
    end
  end

  // Hard stop in case a handshake never completes.
  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic date_t mk_date(int y, int m, int d);
    date_t dt;
    dt.year  = YEAR_W'(y);
    dt.month = MONTH_W'(m);
    dt.day   = DAY_W'(d);
    return dt;
  endfunction

  function automatic date_t valid_date_in(int y);
    int m;
    m = $urandom_range(1, 12);
    return mk_date(y, m, $urandom_range(1, board.days_in_month(y, m)));
  endfunction

  // Any bit pattern the ports allow, clamped years and bogus months included.
  function automatic date_t raw_date();
    return mk_date($urandom_range(0, (1 << YEAR_W) - 1), $urandom_range(0, 15),
                   $urandom_range(0, 31));
  endfunction

  // Called right after a rising edge; returns right after the accepting edge.
  // Hold start high across back-to-back transactions; drop it only for a gap.
  task automatic send_pair(input date_t a, input date_t b);
    int unsigned gap;
    gap = sender_idles ? pick_gap() : 0;
    if (gap != 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    first_year_i   <= a.year;
    first_month_i  <= a.month;
    first_day_i    <= a.day;
    second_year_i  <= b.year;
    second_month_i <= b.month;
    second_day_i   <= b.day;
    start_i        <= 1'b1;
    do @(negedge clk_i); while (busy_o);
    @(posedge clk_i);
  endtask

  // Drop start and hold until every outstanding transaction has reported.
  task automatic drain();
    start_i <= 1'b0;
    do @(posedge clk_i); while (board.pending());
  endtask

  // Write the include-end-day register; the pipeline is empty by now.
  task automatic write_include_end(input bit value);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    board.include_end = value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic run_directed();
    send_pair(mk_date(1, 1, 1), mk_date(9999, 12, 31));       // widest valid span
    send_pair(mk_date(1, 1, 1), mk_date(1, 1, 2));            // one day apart
    send_pair(mk_date(2000, 2, 28), mk_date(2000, 3, 1));     // leap by the 400 rule
    send_pair(mk_date(1900, 2, 28), mk_date(1900, 3, 1));     // century, not leap
    send_pair(mk_date(2024, 2, 28), mk_date(2024, 3, 1));     // ordinary leap year
    send_pair(mk_date(2023, 5, 5), mk_date(2023, 5, 5));      // equal dates
    send_pair(mk_date(2023, 5, 6), mk_date(2023, 5, 5));      // end day first
    send_pair(mk_date(2023, 7, 1), mk_date(2023, 6, 30));     // end month first
    send_pair(mk_date(2024, 1, 1), mk_date(2023, 12, 31));    // end year first
    send_pair(mk_date(0, 1, 1), mk_date(1, 1, 1));            // year zero
    send_pair(mk_date(0, 2, 1), mk_date(0, 3, 1));            // year zero is leap
    send_pair(mk_date(16383, 1, 1), mk_date(9999, 1, 1));     // clamps to equal
    send_pair(mk_date(9998, 6, 1), mk_date(10000, 6, 1));     // end year clamps
    send_pair(mk_date(10000, 6, 1), mk_date(9999, 7, 1));     // start year clamps
    send_pair(mk_date(2023, 0, 5), mk_date(2023, 1, 1));      // month zero
    send_pair(mk_date(2023, 12, 1), mk_date(2023, 13, 1));    // month past December
    send_pair(mk_date(2023, 13, 0), mk_date(2023, 15, 31));
    send_pair(mk_date(2023, 0, 0), mk_date(2023, 15, 31));
    send_pair(mk_date(2023, 1, 31), mk_date(2023, 2, 0));     // day overflow, zero span
    send_pair(mk_date(2023, 2, 31), mk_date(2023, 3, 1));     // day overflow, negative
    send_pair(mk_date(0, 0, 0), mk_date(16383, 15, 31));      // all bits low, then high
    send_pair(mk_date(16383, 15, 31), mk_date(0, 0, 0));
  endtask

  // Mostly well-formed pairs in order, some reversed or equal, some raw noise.
  task automatic run_random(input int count);
    date_t a;
    date_t b;
    date_t swap;
    int unsigned kind;
    int y;
    for (int n = 0; n < count; n++) begin
      if (n % 40 == 0) sender_idles = ($urandom_range(0, 9) >= 3);
      kind = $urandom_range(0, 99);
      y = $urandom_range(1, MAX_YEAR);
      if (kind < 50) begin
        a = valid_date_in(y);
        b = valid_date_in($urandom_range(1, MAX_YEAR));
        if (a > b) begin
          swap = a;
          a = b;
          b = swap;
        end
      end else if (kind < 70) begin
        // Same or nearby year, order left to chance.
        a = valid_date_in(y);
        y = y + $urandom_range(0, 2);
        b = valid_date_in((y > MAX_YEAR) ? MAX_YEAR : y);
      end else if (kind < 78) begin
        a = valid_date_in(y);
        b = a;
      end else if (kind < 88) begin
        // Same month, days drawn from the full field.
        a = valid_date_in(y);
        b = a;
        a.day = DAY_W'($urandom_range(0, 31));
        b.day = DAY_W'($urandom_range(0, 31));
      end else begin
        a = raw_date();
        b = raw_date();
      end
      send_pair(a, b);
    end
    sender_idles = 1'b1;
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed cases run first on the reset value of include end day.
    run_directed();

    write_include_end(1'b0);
    run_directed();
    run_random(130);

    write_include_end(1'b1);
    run_random(65);
    // Let the pipeline run dry before resuming.
    drain();
    run_random(65);

    write_include_end(1'b0);
    run_random(140);

    drain();
    // Catch any stray result after the last expected one.
    repeat (10) @(posedge clk_i);
    if (board.mismatches == 0 && !board.pending())
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
